>>> rtl/mfmc_pkg.sv
// Shared types and constants for the MFM/FM byte codec.
// No dependencies; used by the codec top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package mfmc_pkg;

    typedef enum logic [1:0] {
        KIND_ENC_DATA = 2'd0,
        KIND_ENC_MARK = 2'd1,
        KIND_DECODE   = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    typedef enum logic {
        MODE_MFM = 1'b0,
        MODE_FM  = 1'b1
    } t_line_mode;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] coded_in;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] encoded_word;
        logic [7:0]  decoded_byte;
    } t_out_beat;

    // Mark bytes and their missing-clock cell words.
    localparam logic [7:0]  FM_MARK_INDEX = 8'hFC;
    localparam logic [7:0]  FM_MARK_ID    = 8'hFE;
    localparam logic [7:0]  FM_MARK_DATA  = 8'hFB;
    localparam logic [7:0]  FM_MARK_DEL   = 8'hF8;
    localparam logic [15:0] FM_WORD_INDEX = 16'hF77A;
    localparam logic [15:0] FM_WORD_ID    = 16'hF57E;
    localparam logic [15:0] FM_WORD_DATA  = 16'hF56F;
    localparam logic [15:0] FM_WORD_DEL   = 16'hF56A;

    localparam logic [7:0]  MFM_MARK_A1   = 8'hA1;
    localparam logic [7:0]  MFM_MARK_C2   = 8'hC2;
    localparam logic [15:0] MFM_WORD_A1   = 16'h4489;
    localparam logic [15:0] MFM_WORD_C2   = 16'h5224;

endpackage

`default_nettype wire

>>> rtl/mfm_fm_byte_codec.sv
// MFM/FM floppy byte codec: encodes bytes and marks into 16-bit cell words
// and decodes cell words back into bytes. Depends on mfmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The codec takes one beat per clock while o_stall is low and returns one
// result beat for every input beat: the beat first lands in the input register,
// then its cell word or byte is computed combinationally and loaded into the
// result register. Sustained rate, with the output not stalled, is one
// beat per cycle; the only carried state is the last data bit encoded, which
// is updated as each encode beat moves into the result register, so beats
// are coded strictly in arrival order. A stall on the output side holds the
// result register and, once the input register is also full, raises o_stall.
// The line mode register (0 = MFM, 1 = FM) is written with i_cfg_we and
// should only be changed while no beats are in flight.
module mfm_fm_byte_codec (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire                   i_cfg_data,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  mfmc_pkg::t_in_beat    i_in,
    output logic                  o_valid,
    input  wire                   i_stall,
    output mfmc_pkg::t_out_beat   o_out
);
    import mfmc_pkg::*;

    t_line_mode r_mode;
    logic       r_last_bit;
    logic       n_last_bit;

    logic       r_in_vld;
    t_in_beat   r_in;
    logic       r_out_vld;
    t_out_beat  r_out;
    t_out_beat  n_out;

    logic       out_free;
    logic       in_move;

    logic [15:0] fm_word;
    logic [15:0] mfm_word;
    logic [8:0]  mfm_bits;
    logic [7:0]  dec_byte;

    // The result register can take a new beat when empty or being drained.
    assign out_free = !r_out_vld || !i_stall;
    assign in_move  = r_in_vld && out_free;
    assign o_stall  = r_in_vld && !out_free;
    assign o_valid  = r_out_vld;
    assign o_out    = r_out;

    // The data bits with the last bit of the previous byte on their left.
    assign mfm_bits = {r_last_bit, r_in.data_byte};

    // Cell words: each data bit sits at an even position with its clock above it.
    // In MFM the clock of bit 7 looks back at the last bit of the previous byte.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            fm_word[2*i]      = r_in.data_byte[i];
            fm_word[2*i+1]    = 1'b1;
            mfm_word[2*i]     = r_in.data_byte[i];
            mfm_word[2*i+1]   = !mfm_bits[i+1] && !mfm_bits[i];
            dec_byte[i]       = r_in.coded_in[2*i];
        end
    end

    always_comb begin
        n_out      = '0;
        n_last_bit = r_last_bit;
        case (r_in.kind)
            KIND_ENC_DATA, KIND_ENC_MARK: begin
                n_last_bit = r_in.data_byte[0];
                if (r_mode == MODE_FM) begin
                    n_out.encoded_word = fm_word;
                    if (r_in.kind == KIND_ENC_MARK) begin
                        case (r_in.data_byte)
                            FM_MARK_INDEX: n_out.encoded_word = FM_WORD_INDEX;
                            FM_MARK_ID:    n_out.encoded_word = FM_WORD_ID;
                            FM_MARK_DATA:  n_out.encoded_word = FM_WORD_DATA;
                            FM_MARK_DEL:   n_out.encoded_word = FM_WORD_DEL;
                            default:       n_out.encoded_word = fm_word;
                        endcase
                    end
                end else begin
                    n_out.encoded_word = mfm_word;
                    if (r_in.kind == KIND_ENC_MARK) begin
                        case (r_in.data_byte)
                            MFM_MARK_A1: n_out.encoded_word = MFM_WORD_A1;
                            MFM_MARK_C2: n_out.encoded_word = MFM_WORD_C2;
                            default:     n_out.encoded_word = mfm_word;
                        endcase
                    end
                end
            end
            KIND_DECODE: begin
                n_out.decoded_byte = dec_byte;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_MFM;
            r_last_bit <= 1'b0;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= t_line_mode'(i_cfg_data);
            end
            if (!o_stall) begin
                r_in_vld <= i_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (in_move) begin
                r_last_bit <= n_last_bit;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_in;
        end
        if (in_move) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mfmc_checker.sv
// Port-level checker for the MFM/FM byte codec, bound to its top level.
// Depends on mfmc_pkg and on mfm_fm_byte_codec.
`timescale 1ns / 1ps
`default_nettype none

module mfmc_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   o_stall,
    input  mfmc_pkg::t_in_beat    i_in,
    input  wire                   o_valid,
    input  wire                   i_stall,
    input  mfmc_pkg::t_out_beat   o_out
);
    import mfmc_pkg::*;

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result beat changed while stalled");

    // A stalled input beat stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_in))
        else $error("input beat changed while stalled");

    // The input side only backs up when a result is waiting.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

    // A result never carries both an encoded word and a decoded byte.
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out.decoded_byte != 8'd0) |-> o_out.encoded_word == 16'd0)
        else $error("encode and decode fields both nonzero");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind mfm_fm_byte_codec mfmc_checker u_mfmc_checker (.*);

`default_nettype wire
